// ----- sv/bcgd_pkg.sv -----
// ----------------------------------------------------------------------------
// bcgd_pkg
// Types, codes and the gesture transition function of the button gesture
// decoder.
// ----------------------------------------------------------------------------
package bcgd_pkg;

  // Gesture machine states
  typedef enum logic [3:0] {
    G_IDLE        = 4'd0,
    G_PRESSED     = 4'd1,
    G_RELEASED    = 4'd2,
    G_LONG        = 4'd3,
    G_REPEAT      = 4'd4,
    G_WAITRELEASE = 4'd5,
    G_PRESSED2    = 4'd6,
    G_RELEASED2   = 4'd7,
    G_LONG2       = 4'd8,
    G_REPEAT2     = 4'd9,
    G_PRESSED3    = 4'd10,
    G_LONG3       = 4'd11,
    G_REPEAT3     = 4'd12,
    G_WAITPRESS   = 4'd13
  } gesture_t;

  // Action codes, also the bit positions in handler_present
  typedef enum logic [3:0] {
    ACT_CLICK   = 4'd0,
    ACT_DCLICK  = 4'd1,
    ACT_TCLICK  = 4'd2,
    ACT_RELEASE = 4'd3,
    ACT_PRESS   = 4'd4,
    ACT_PRESS2  = 4'd5,
    ACT_PRESS3  = 4'd6,
    ACT_LONG    = 4'd7,
    ACT_REPEAT  = 4'd8,
    ACT_LONG2   = 4'd9,
    ACT_REPEAT2 = 4'd10,
    ACT_LONG3   = 4'd11,
    ACT_REPEAT3 = 4'd12
  } act_t;

  // Fallback command when no handler is present
  typedef enum logic [1:0] {
    DEF_NONE = 2'd0,
    DEF_ON   = 2'd1,
    DEF_OFF  = 2'd2
  } def_cmd_t;

  // Bit of handler_present that marks a default target
  localparam int unsigned HP_DEFAULT_BIT = 13;
  localparam int unsigned HP_WIDTH       = 14;

  // Configuration register indexes
  localparam logic [2:0] CFG_ACTIVE_HIGH     = 3'd0;
  localparam logic [2:0] CFG_LONG_PRESS      = 3'd1;
  localparam logic [2:0] CFG_REPEAT_DELAY    = 3'd2;
  localparam logic [2:0] CFG_REPEAT_PERIOD   = 3'd3;
  localparam logic [2:0] CFG_IDLE_TIMEOUT    = 3'd4;
  localparam logic [2:0] CFG_DEBOUNCE        = 3'd5;
  localparam logic [2:0] CFG_HANDLER_PRESENT = 3'd6;

  // Configuration reset values
  localparam logic [15:0] RST_LONG_PRESS    = 16'd800;
  localparam logic [15:0] RST_REPEAT_DELAY  = 16'd400;
  localparam logic [15:0] RST_REPEAT_PERIOD = 16'd200;
  localparam logic [15:0] RST_IDLE_TIMEOUT  = 16'd400;
  localparam logic [7:0]  RST_DEBOUNCE      = 8'd3;

  // Configuration registers
  typedef struct packed {
    logic                active_high;
    logic [15:0]         long_press_ms;
    logic [15:0]         repeat_delay_ms;
    logic [15:0]         repeat_period_ms;
    logic [15:0]         idle_timeout_ms;
    logic [7:0]          debounce_polls;
    logic [HP_WIDTH-1:0] handler_present;
  } cfg_t;

  // Gesture related state touched by a transition
  typedef struct packed {
    gesture_t   gesture;
    logic [2:0] toggles;
    logic       pending_valid;
    gesture_t   pending_gesture;
  } gst_t;

  // One action event, last field in the lowest bits
  typedef struct packed {
    gesture_t gesture_after;
    logic     toggle_value;
    def_cmd_t default_command;
    logic     handler_given;
    act_t     action;
  } ev_t;

  // Outcome of one transition attempt
  typedef struct packed {
    gst_t st;
    logic ok;
    logic ev_valid;
    ev_t  ev;
  } chg_t;

  // Try to move the gesture machine to ng
  function automatic chg_t change_gesture(gst_t st, gesture_t ng, logic intr,
                                          logic flushing, logic [HP_WIDTH-1:0] hp);
    chg_t     r;
    act_t     act;
    logic     act_v;
    logic     tog;
    def_cmd_t defc;
    logic     has;
    r        = '0;
    r.st     = st;
    r.ok     = 1'b1;
    act      = ACT_CLICK;
    act_v    = 1'b0;
    tog      = 1'b0;
    defc     = DEF_NONE;
    has      = 1'b0;
    if (!flushing && st.pending_valid) begin
      // blocked while a deferred transition waits
      r.ok = 1'b0;
    end else begin
      unique case (ng)
        G_IDLE: begin
          act_v = 1'b1;
          if (st.gesture == G_RELEASED) begin
            act = ACT_CLICK;
            tog = st.toggles[0];
          end else if (st.gesture == G_RELEASED2) begin
            act = ACT_DCLICK;
            tog = st.toggles[1];
          end else if (st.gesture == G_PRESSED3) begin
            act = ACT_TCLICK;
            tog = st.toggles[2];
          end else if (st.gesture != G_WAITPRESS) begin
            act = ACT_RELEASE;
          end else begin
            act_v = 1'b0;
          end
        end
        G_PRESSED: begin
          act_v = 1'b1;
          act   = ACT_PRESS;
          tog   = st.toggles[0];
          r.st.toggles[0] = ~st.toggles[0];
          if (!hp[ACT_PRESS]) defc = DEF_ON;
        end
        G_PRESSED2: begin
          act_v = 1'b1;
          act   = ACT_PRESS2;
          tog   = st.toggles[1];
          r.st.toggles[1] = ~st.toggles[1];
        end
        G_PRESSED3: begin
          act_v = 1'b1;
          act   = ACT_PRESS3;
          tog   = st.toggles[2];
          r.st.toggles[2] = ~st.toggles[2];
        end
        G_RELEASED, G_WAITPRESS, G_RELEASED2: begin
          act_v = 1'b1;
          act   = ACT_RELEASE;
          if (!hp[ACT_RELEASE]) defc = DEF_OFF;
        end
        G_LONG: begin
          act_v = 1'b1;
          act   = ACT_LONG;
          tog   = st.toggles[0];
        end
        G_REPEAT: begin
          act_v = 1'b1;
          act   = ACT_REPEAT;
          tog   = st.toggles[0];
        end
        G_LONG2: begin
          act_v = 1'b1;
          act   = ACT_LONG2;
          tog   = st.toggles[1];
        end
        G_REPEAT2: begin
          act_v = 1'b1;
          act   = ACT_REPEAT2;
          tog   = st.toggles[1];
        end
        G_LONG3: begin
          act_v = 1'b1;
          act   = ACT_LONG3;
          tog   = st.toggles[2];
        end
        G_REPEAT3: begin
          act_v = 1'b1;
          act   = ACT_REPEAT3;
          tog   = st.toggles[2];
        end
        default: begin
          act_v = 1'b0;
        end
      endcase

      if (!hp[HP_DEFAULT_BIT]) defc = DEF_NONE;
      has = act_v && hp[act];

      if (!has && (defc == DEF_NONE)) begin
        // silent transition, also on interrupt polls
        r.st.gesture       = ng;
        r.st.pending_valid = 1'b0;
      end else if (!intr) begin
        r.st.gesture              = ng;
        r.st.pending_valid        = 1'b0;
        r.ev_valid                = 1'b1;
        r.ev.action               = act;
        r.ev.handler_given        = has;
        r.ev.default_command      = has ? DEF_NONE : defc;
        r.ev.toggle_value         = tog;
        r.ev.gesture_after        = ng;
      end else if (ng != st.gesture) begin
        // defer until the next normal poll
        r.st.pending_gesture = ng;
        r.st.pending_valid   = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

// ----- sv/bcgd_step.sv -----
// ----------------------------------------------------------------------------
// bcgd_step
// Combinational next-state logic for one poll: pending flush, timed
// transition, debounced edge, and the up to three events they produce.
// ----------------------------------------------------------------------------
module bcgd_step #(
  parameter int TIME_WIDTH = 16
) (
  input  bcgd_pkg::cfg_t          cfg,
  input  bcgd_pkg::gst_t          gst,
  input  logic                    accepted_level,
  input  logic [7:0]              bounce_left,
  input  logic [TIME_WIDTH-1:0]   stamp_ms,
  input  logic                    level,
  input  logic [15:0]             now_ms,
  input  logic                    mode,
  output bcgd_pkg::gst_t          gst_next,
  output logic                    accepted_level_next,
  output logic [7:0]              bounce_left_next,
  output logic [TIME_WIDTH-1:0]   stamp_ms_next,
  output bcgd_pkg::ev_t [2:0]     ev,
  output logic [1:0]              ev_count
);

  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] elapsed;

  assign now_t   = TIME_WIDTH'(now_ms);
  assign elapsed = now_t - stamp_ms;

  // wait of zero is always over; otherwise wrapping elapsed time compare
  function automatic logic time_over(logic [TIME_WIDTH-1:0] el, logic [15:0] wait_ms);
    return (wait_ms == 16'd0) || (32'(el) >= 32'(wait_ms));
  endfunction

  always_comb begin
    bcgd_pkg::chg_t     c0, c1, c2;
    bcgd_pkg::gst_t     s0, s1;
    bcgd_pkg::gesture_t t_tgt, e_tgt;
    bcgd_pkg::ev_t      e0, e1, e2;
    logic               v0, v1, v2;
    logic               t_go, t_restamp, e_go, cur, no_future;
    logic [bcgd_pkg::HP_WIDTH-1:0] hp;

    hp = cfg.handler_present;
    c0 = '0;
    c1 = '0;
    c2 = '0;

    // flush of a deferred transition on a normal poll
    s0 = gst;
    if (gst.pending_valid && !mode) begin
      if (gst.gesture == gst.pending_gesture) begin
        s0.pending_valid = 1'b0;
      end else begin
        c0 = bcgd_pkg::change_gesture(gst, gst.pending_gesture, 1'b0, 1'b1, hp);
        s0 = c0.st;
      end
    end
    e0 = c0.ev;
    v0 = c0.ev_valid;

    // timed transitions, normal polls only
    t_go      = 1'b0;
    t_restamp = 1'b0;
    t_tgt     = bcgd_pkg::G_IDLE;
    if (!mode) begin
      unique case (s0.gesture)
        bcgd_pkg::G_PRESSED: begin
          t_go  = time_over(elapsed, cfg.long_press_ms);
          t_tgt = (!hp[bcgd_pkg::ACT_LONG] && !hp[bcgd_pkg::ACT_REPEAT]) ?
                  bcgd_pkg::G_WAITRELEASE : bcgd_pkg::G_LONG;
        end
        bcgd_pkg::G_PRESSED2: begin
          t_go  = time_over(elapsed, cfg.long_press_ms);
          t_tgt = (!hp[bcgd_pkg::ACT_LONG2] && !hp[bcgd_pkg::ACT_REPEAT2]) ?
                  bcgd_pkg::G_WAITRELEASE : bcgd_pkg::G_LONG2;
        end
        bcgd_pkg::G_PRESSED3: begin
          t_go = time_over(elapsed, cfg.long_press_ms);
          if (!hp[bcgd_pkg::ACT_LONG3] && !hp[bcgd_pkg::ACT_REPEAT3]) begin
            t_tgt = hp[bcgd_pkg::ACT_PRESS3] ? bcgd_pkg::G_WAITRELEASE
                                             : bcgd_pkg::G_PRESSED2;
          end else begin
            t_tgt = bcgd_pkg::G_LONG3;
          end
        end
        bcgd_pkg::G_LONG: begin
          t_go  = time_over(elapsed, cfg.repeat_delay_ms);
          t_tgt = bcgd_pkg::G_REPEAT;
          t_restamp = t_go;
        end
        bcgd_pkg::G_REPEAT: begin
          t_go  = time_over(elapsed, cfg.repeat_period_ms);
          t_tgt = bcgd_pkg::G_REPEAT;
          t_restamp = t_go;
        end
        bcgd_pkg::G_LONG2: begin
          t_go  = time_over(elapsed, cfg.repeat_delay_ms);
          t_tgt = bcgd_pkg::G_REPEAT2;
          t_restamp = t_go;
        end
        bcgd_pkg::G_REPEAT2: begin
          t_go  = time_over(elapsed, cfg.repeat_period_ms);
          t_tgt = bcgd_pkg::G_REPEAT2;
          t_restamp = t_go;
        end
        bcgd_pkg::G_LONG3: begin
          t_go  = time_over(elapsed, cfg.repeat_delay_ms);
          t_tgt = bcgd_pkg::G_REPEAT3;
          t_restamp = t_go;
        end
        bcgd_pkg::G_REPEAT3: begin
          t_go  = time_over(elapsed, cfg.repeat_period_ms);
          t_tgt = bcgd_pkg::G_REPEAT3;
          t_restamp = t_go;
        end
        bcgd_pkg::G_RELEASED, bcgd_pkg::G_RELEASED2, bcgd_pkg::G_WAITPRESS: begin
          t_go  = time_over(elapsed, cfg.idle_timeout_ms);
          t_tgt = bcgd_pkg::G_IDLE;
        end
        default: begin
          t_go = 1'b0;
        end
      endcase
    end

    s1 = s0;
    if (t_go) begin
      c1 = bcgd_pkg::change_gesture(s0, t_tgt, 1'b0, 1'b0, hp);
      s1 = c1.st;
    end
    e1 = c1.ev;
    v1 = c1.ev_valid;

    // debounced edge
    cur       = (level == cfg.active_high);
    no_future = !hp[bcgd_pkg::ACT_PRESS2] && !hp[bcgd_pkg::ACT_LONG2] &&
                !hp[bcgd_pkg::ACT_REPEAT2] && !hp[bcgd_pkg::ACT_DCLICK];

    e_go  = 1'b0;
    e_tgt = bcgd_pkg::G_IDLE;
    if (cur) begin
      unique case (s1.gesture)
        bcgd_pkg::G_IDLE: begin
          e_go  = 1'b1;
          e_tgt = bcgd_pkg::G_PRESSED;
        end
        bcgd_pkg::G_RELEASED, bcgd_pkg::G_WAITPRESS: begin
          e_go  = 1'b1;
          e_tgt = no_future ? bcgd_pkg::G_PRESSED : bcgd_pkg::G_PRESSED2;
        end
        bcgd_pkg::G_RELEASED2: begin
          e_go  = 1'b1;
          e_tgt = bcgd_pkg::G_PRESSED3;
        end
        default: begin
          e_go = 1'b0;
        end
      endcase
    end else begin
      unique case (s1.gesture)
        bcgd_pkg::G_PRESSED: begin
          e_go  = 1'b1;
          e_tgt = bcgd_pkg::G_RELEASED;
        end
        bcgd_pkg::G_LONG, bcgd_pkg::G_REPEAT, bcgd_pkg::G_WAITRELEASE: begin
          e_go  = 1'b1;
          e_tgt = bcgd_pkg::G_WAITPRESS;
        end
        bcgd_pkg::G_PRESSED2: begin
          e_go  = 1'b1;
          e_tgt = no_future ? bcgd_pkg::G_IDLE : bcgd_pkg::G_RELEASED2;
        end
        bcgd_pkg::G_LONG2, bcgd_pkg::G_REPEAT2, bcgd_pkg::G_LONG3,
        bcgd_pkg::G_REPEAT3, bcgd_pkg::G_PRESSED3: begin
          e_go  = 1'b1;
          e_tgt = bcgd_pkg::G_IDLE;
        end
        default: begin
          e_go = 1'b0;
        end
      endcase
    end

    gst_next            = s1;
    accepted_level_next = accepted_level;
    bounce_left_next    = bounce_left;
    stamp_ms_next       = t_restamp ? now_t : stamp_ms;
    if (cur != accepted_level) begin
      if (bounce_left != 8'd0) begin
        bounce_left_next = bounce_left - 8'd1;
      end else begin
        stamp_ms_next = now_t;
        if (e_go) begin
          c2       = bcgd_pkg::change_gesture(s1, e_tgt, mode, 1'b0, hp);
          gst_next = c2.st;
          if (c2.ok) accepted_level_next = cur;
        end else begin
          accepted_level_next = cur;
        end
      end
    end else begin
      bounce_left_next = cfg.debounce_polls;
    end
    e2 = c2.ev;
    v2 = c2.ev_valid;

    // pack valid events to the front, in order
    ev[0]    = v0 ? e0 : (v1 ? e1 : e2);
    ev[1]    = (v0 && v1) ? e1 : e2;
    ev[2]    = e2;
    ev_count = 2'(v0) + 2'(v1) + 2'(v2);
  end

endmodule

// ----- sv/button_click_gesture_decoder.sv -----
// ----------------------------------------------------------------------------
// button_click_gesture_decoder
// Debounced push-button decoder for clicks, multi-clicks, long press and
// auto-repeat, one action event per fired transition.
// ----------------------------------------------------------------------------
// The first event of a poll appears in the cycle after the poll is taken.
// One poll per cycle while polls yield at most one event and m_tready is high;
// a poll yielding up to 3 events hands them out one by one on the single event
// output, and the next poll is taken in the cycle its last event is handed over.
// Reset (synchronous, rst high): gesture idle, all state cleared, config
// registers to their defaults, no events pending.
module button_click_gesture_decoder #(
  parameter int TIME_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // poll input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [0] level, [16:1] now_ms, [23:17] zero
  input  logic [0:0]  s_tuser,   // [0] mode
  // event output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [3:0] action, [4] handler_given,
                                 // [6:5] default_command, [7] toggle_value,
                                 // [11:8] gesture_after, [15:12] zero
  output logic        m_tlast    // last event of the poll
);

  bcgd_pkg::cfg_t        cfg;
  bcgd_pkg::gst_t        gst, gst_next;
  logic                  accepted_level, accepted_level_next;
  logic [7:0]            bounce_left, bounce_left_next;
  logic [TIME_WIDTH-1:0] stamp_ms, stamp_ms_next;
  bcgd_pkg::ev_t [2:0]   step_ev;
  logic [1:0]            step_count;
  bcgd_pkg::ev_t [2:0]   obuf;
  logic [1:0]            ocount;
  logic                  in_fire, out_fire;

  assign m_tvalid = (ocount != 2'd0);
  assign out_fire = m_tvalid && m_tready;
  // take a poll once the event buffer is empty or its final event drains
  assign s_tready = (ocount == 2'd0) || ((ocount == 2'd1) && m_tready);
  assign in_fire  = s_tvalid && s_tready;
  assign m_tdata  = {4'd0, obuf[0]};
  assign m_tlast  = (ocount == 2'd1);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_high      <= 1'b0;
      cfg.long_press_ms    <= bcgd_pkg::RST_LONG_PRESS;
      cfg.repeat_delay_ms  <= bcgd_pkg::RST_REPEAT_DELAY;
      cfg.repeat_period_ms <= bcgd_pkg::RST_REPEAT_PERIOD;
      cfg.idle_timeout_ms  <= bcgd_pkg::RST_IDLE_TIMEOUT;
      cfg.debounce_polls   <= bcgd_pkg::RST_DEBOUNCE;
      cfg.handler_present  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bcgd_pkg::CFG_ACTIVE_HIGH:     cfg.active_high      <= cfg_data[0];
        bcgd_pkg::CFG_LONG_PRESS:      cfg.long_press_ms    <= cfg_data;
        bcgd_pkg::CFG_REPEAT_DELAY:    cfg.repeat_delay_ms  <= cfg_data;
        bcgd_pkg::CFG_REPEAT_PERIOD:   cfg.repeat_period_ms <= cfg_data;
        bcgd_pkg::CFG_IDLE_TIMEOUT:    cfg.idle_timeout_ms  <= cfg_data;
        bcgd_pkg::CFG_DEBOUNCE:        cfg.debounce_polls   <= cfg_data[7:0];
        bcgd_pkg::CFG_HANDLER_PRESENT: begin
          cfg.handler_present <= cfg_data[bcgd_pkg::HP_WIDTH-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // per-poll next-state logic
  bcgd_step #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_step (
    .cfg                 (cfg),
    .gst                 (gst),
    .accepted_level      (accepted_level),
    .bounce_left         (bounce_left),
    .stamp_ms            (stamp_ms),
    .level               (s_tdata[0]),
    .now_ms              (s_tdata[16:1]),
    .mode                (s_tuser[0]),
    .gst_next            (gst_next),
    .accepted_level_next (accepted_level_next),
    .bounce_left_next    (bounce_left_next),
    .stamp_ms_next       (stamp_ms_next),
    .ev                  (step_ev),
    .ev_count            (step_count)
  );

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      gst.gesture         <= bcgd_pkg::G_IDLE;
      gst.toggles         <= '0;
      gst.pending_valid   <= 1'b0;
      gst.pending_gesture <= bcgd_pkg::G_IDLE;
      accepted_level      <= 1'b0;
      bounce_left         <= '0;
      stamp_ms            <= '0;
    end else if (in_fire) begin
      gst            <= gst_next;
      accepted_level <= accepted_level_next;
      bounce_left    <= bounce_left_next;
      stamp_ms       <= stamp_ms_next;
    end
  end

  // event buffer count
  always_ff @(posedge clk) begin
    if (rst) begin
      ocount <= 2'd0;
    end else if (in_fire) begin
      ocount <= step_count;
    end else if (out_fire) begin
      ocount <= ocount - 2'd1;
    end
  end

  // event buffer payload, shifts toward slot 0 as events drain
  always_ff @(posedge clk) begin
    if (in_fire) begin
      obuf <= step_ev;
    end else if (out_fire) begin
      obuf[0] <= obuf[1];
      obuf[1] <= obuf[2];
    end
  end

endmodule

// ----- tb/sv/bcgd_action_checker.sv -----
// ----------------------------------------------------------------------------
// bcgd_action_checker
// Watches the poll, event and configuration ports of the button gesture
// decoder, runs its own gesture machine on every accepted poll and compares
// each event handed out against the oldest one still owed.
// ----------------------------------------------------------------------------
module bcgd_action_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // [0] level, [16:1] now_ms, [23:17] zero
  input  logic [0:0]  s_tuser,   // [0] mode
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // [3:0] action, [4] handler_given,
                                 // [6:5] default_command, [7] toggle_value,
                                 // [11:8] gesture_after, [15:12] zero
  input  logic        m_tlast,
  output int          fails,
  output int          queued
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    bcgd_pkg::act_t     action;
    logic               handler_given;
    bcgd_pkg::def_cmd_t default_command;
    logic               toggle_value;
    bcgd_pkg::gesture_t gesture_after;
    logic               last;
  } gesture_event_t;

  // register copies
  logic                          active_high;
  logic [15:0]                   long_press_ms, repeat_delay_ms;
  logic [15:0]                   repeat_period_ms, idle_timeout_ms;
  logic [7:0]                    debounce_polls;
  logic [bcgd_pkg::HP_WIDTH-1:0] hp;

  // gesture machine copy
  bcgd_pkg::gesture_t gest, pend_gest;
  logic               pend_valid;
  logic               acc_level;
  logic [7:0]         bounce_left;
  logic [15:0]        stamp_ms;
  logic [2:0]         toggles;

  gesture_event_t poll_actions[$];   // events of the poll being decoded
  gesture_event_t action_queue[$];   // events owed by the block, oldest first

  // wrapping elapsed-time test against the last stamp
  function automatic bit time_elapsed(logic [15:0] now, logic [15:0] span);
    logic [15:0] gone;
    gone = now - stamp_ms;
    return (span == 16'd0) || (gone >= span);
  endfunction

  // one transition attempt; returns 0 when refused by a waiting deferral
  function automatic bit move_gesture(bcgd_pkg::gesture_t ng, bit intr, bit flushing);
    bcgd_pkg::act_t     act;
    bit                 act_v;
    logic               tog;
    bcgd_pkg::def_cmd_t defc;
    bit                 has;
    gesture_event_t     ev;
    act   = bcgd_pkg::ACT_CLICK;
    act_v = 1'b1;
    tog   = 1'b0;
    defc  = bcgd_pkg::DEF_NONE;
    if (!flushing && pend_valid) return 1'b0;
    case (ng)
      bcgd_pkg::G_IDLE: begin
        if (gest == bcgd_pkg::G_RELEASED) begin
          act = bcgd_pkg::ACT_CLICK;
          tog = toggles[0];
        end else if (gest == bcgd_pkg::G_RELEASED2) begin
          act = bcgd_pkg::ACT_DCLICK;
          tog = toggles[1];
        end else if (gest == bcgd_pkg::G_PRESSED3) begin
          act = bcgd_pkg::ACT_TCLICK;
          tog = toggles[2];
        end else if (gest != bcgd_pkg::G_WAITPRESS) begin
          act = bcgd_pkg::ACT_RELEASE;
        end else begin
          act_v = 1'b0;
        end
      end
      bcgd_pkg::G_PRESSED: begin
        act = bcgd_pkg::ACT_PRESS;
        tog = toggles[0];
        toggles[0] = ~toggles[0];
        if (!hp[bcgd_pkg::ACT_PRESS]) defc = bcgd_pkg::DEF_ON;
      end
      bcgd_pkg::G_PRESSED2: begin
        act = bcgd_pkg::ACT_PRESS2;
        tog = toggles[1];
        toggles[1] = ~toggles[1];
      end
      bcgd_pkg::G_PRESSED3: begin
        act = bcgd_pkg::ACT_PRESS3;
        tog = toggles[2];
        toggles[2] = ~toggles[2];
      end
      bcgd_pkg::G_RELEASED, bcgd_pkg::G_WAITPRESS, bcgd_pkg::G_RELEASED2: begin
        act = bcgd_pkg::ACT_RELEASE;
        if (!hp[bcgd_pkg::ACT_RELEASE]) defc = bcgd_pkg::DEF_OFF;
      end
      bcgd_pkg::G_LONG: begin
        act = bcgd_pkg::ACT_LONG;
        tog = toggles[0];
      end
      bcgd_pkg::G_REPEAT: begin
        act = bcgd_pkg::ACT_REPEAT;
        tog = toggles[0];
      end
      bcgd_pkg::G_LONG2: begin
        act = bcgd_pkg::ACT_LONG2;
        tog = toggles[1];
      end
      bcgd_pkg::G_REPEAT2: begin
        act = bcgd_pkg::ACT_REPEAT2;
        tog = toggles[1];
      end
      bcgd_pkg::G_LONG3: begin
        act = bcgd_pkg::ACT_LONG3;
        tog = toggles[2];
      end
      bcgd_pkg::G_REPEAT3: begin
        act = bcgd_pkg::ACT_REPEAT3;
        tog = toggles[2];
      end
      default: act_v = 1'b0;
    endcase
    if (!hp[bcgd_pkg::HP_DEFAULT_BIT]) defc = bcgd_pkg::DEF_NONE;
    has = act_v && hp[act];

    if (!has && defc == bcgd_pkg::DEF_NONE) begin
      // nothing to report: move at once, drop any deferral
      gest       = ng;
      pend_valid = 1'b0;
    end else if (!intr) begin
      gest       = ng;
      pend_valid = 1'b0;
      if (poll_actions.size() < 3) begin
        ev.action          = act;
        ev.handler_given   = has;
        ev.default_command = has ? bcgd_pkg::DEF_NONE : defc;
        ev.toggle_value    = tog;
        ev.gesture_after   = ng;
        ev.last            = 1'b0;
        poll_actions.push_back(ev);
      end
    end else if (ng != gest) begin
      // interrupt poll: hold the move until the next normal poll
      pend_gest  = ng;
      pend_valid = 1'b1;
    end
    return 1'b1;
  endfunction

  // hold timer of a pressed state
  function automatic void press_timer(logic [15:0] now, bcgd_pkg::act_t long_act,
                                      bcgd_pkg::act_t rep_act,
                                      bcgd_pkg::gesture_t long_g);
    if (time_elapsed(now, long_press_ms)) begin
      if (!hp[long_act] && !hp[rep_act])
        void'(move_gesture(bcgd_pkg::G_WAITRELEASE, 1'b0, 1'b0));
      else void'(move_gesture(long_g, 1'b0, 1'b0));
    end
  endfunction

  // repeat timer; restamps whether or not the move went through
  function automatic void repeat_timer(logic [15:0] now, logic [15:0] span,
                                       bcgd_pkg::gesture_t rep_g);
    if (time_elapsed(now, span)) begin
      void'(move_gesture(rep_g, 1'b0, 1'b0));
      stamp_ms = now;
    end
  endfunction

  // full decode of one poll, appending its events to the queue
  function automatic void decode_poll(logic level, logic [15:0] now, bit intr);
    logic cur;
    bit   ok;
    bit   no_future;
    poll_actions.delete();

    // deferred move goes first on a normal poll
    if (pend_valid && !intr) begin
      if (gest == pend_gest) pend_valid = 1'b0;
      else void'(move_gesture(pend_gest, 1'b0, 1'b1));
    end

    cur = (level == active_high);

    // timed moves, normal polls only
    if (!intr) begin
      case (gest)
        bcgd_pkg::G_PRESSED:
          press_timer(now, bcgd_pkg::ACT_LONG, bcgd_pkg::ACT_REPEAT, bcgd_pkg::G_LONG);
        bcgd_pkg::G_LONG:
          repeat_timer(now, repeat_delay_ms, bcgd_pkg::G_REPEAT);
        bcgd_pkg::G_REPEAT:
          repeat_timer(now, repeat_period_ms, bcgd_pkg::G_REPEAT);
        bcgd_pkg::G_PRESSED2:
          press_timer(now, bcgd_pkg::ACT_LONG2, bcgd_pkg::ACT_REPEAT2, bcgd_pkg::G_LONG2);
        bcgd_pkg::G_LONG2:
          repeat_timer(now, repeat_delay_ms, bcgd_pkg::G_REPEAT2);
        bcgd_pkg::G_REPEAT2:
          repeat_timer(now, repeat_period_ms, bcgd_pkg::G_REPEAT2);
        bcgd_pkg::G_PRESSED3: begin
          if (time_elapsed(now, long_press_ms)) begin
            if (!hp[bcgd_pkg::ACT_LONG3] && !hp[bcgd_pkg::ACT_REPEAT3])
              void'(move_gesture(hp[bcgd_pkg::ACT_PRESS3] ? bcgd_pkg::G_WAITRELEASE
                                                          : bcgd_pkg::G_PRESSED2,
                                 1'b0, 1'b0));
            else
              void'(move_gesture(bcgd_pkg::G_LONG3, 1'b0, 1'b0));
          end
        end
        bcgd_pkg::G_LONG3:
          repeat_timer(now, repeat_delay_ms, bcgd_pkg::G_REPEAT3);
        bcgd_pkg::G_REPEAT3:
          repeat_timer(now, repeat_period_ms, bcgd_pkg::G_REPEAT3);
        bcgd_pkg::G_RELEASED, bcgd_pkg::G_RELEASED2, bcgd_pkg::G_WAITPRESS: begin
          if (time_elapsed(now, idle_timeout_ms))
            void'(move_gesture(bcgd_pkg::G_IDLE, 1'b0, 1'b0));
        end
        default: ;
      endcase
    end

    no_future = !hp[bcgd_pkg::ACT_PRESS2] && !hp[bcgd_pkg::ACT_LONG2] &&
                !hp[bcgd_pkg::ACT_REPEAT2] && !hp[bcgd_pkg::ACT_DCLICK];

    // debounce, then edge moves
    if (cur != acc_level) begin
      if (bounce_left != 8'd0) begin
        bounce_left = bounce_left - 8'd1;
      end else begin
        ok       = 1'b1;
        stamp_ms = now;
        if (cur) begin
          case (gest)
            bcgd_pkg::G_IDLE: ok = move_gesture(bcgd_pkg::G_PRESSED, intr, 1'b0);
            bcgd_pkg::G_RELEASED, bcgd_pkg::G_WAITPRESS:
              ok = move_gesture(no_future ? bcgd_pkg::G_PRESSED : bcgd_pkg::G_PRESSED2,
                                intr, 1'b0);
            bcgd_pkg::G_RELEASED2: ok = move_gesture(bcgd_pkg::G_PRESSED3, intr, 1'b0);
            default: ;
          endcase
        end else begin
          case (gest)
            bcgd_pkg::G_PRESSED: ok = move_gesture(bcgd_pkg::G_RELEASED, intr, 1'b0);
            bcgd_pkg::G_LONG, bcgd_pkg::G_REPEAT, bcgd_pkg::G_WAITRELEASE:
              ok = move_gesture(bcgd_pkg::G_WAITPRESS, intr, 1'b0);
            bcgd_pkg::G_PRESSED2:
              ok = move_gesture(no_future ? bcgd_pkg::G_IDLE : bcgd_pkg::G_RELEASED2,
                                intr, 1'b0);
            bcgd_pkg::G_LONG2, bcgd_pkg::G_REPEAT2, bcgd_pkg::G_LONG3,
            bcgd_pkg::G_REPEAT3, bcgd_pkg::G_PRESSED3:
              ok = move_gesture(bcgd_pkg::G_IDLE, intr, 1'b0);
            default: ;
          endcase
        end
        if (ok) acc_level = cur;
      end
    end else begin
      bounce_left = debounce_polls;
    end

    if (poll_actions.size() > 0) poll_actions[poll_actions.size() - 1].last = 1'b1;
    foreach (poll_actions[i]) action_queue.push_back(poll_actions[i]);
  endfunction

  // watch all three ports at each edge
  always @(posedge clk) begin : watch
    gesture_event_t got, want;
    if (rst) begin
      active_high      = 1'b0;
      long_press_ms    = bcgd_pkg::RST_LONG_PRESS;
      repeat_delay_ms  = bcgd_pkg::RST_REPEAT_DELAY;
      repeat_period_ms = bcgd_pkg::RST_REPEAT_PERIOD;
      idle_timeout_ms  = bcgd_pkg::RST_IDLE_TIMEOUT;
      debounce_polls   = bcgd_pkg::RST_DEBOUNCE;
      hp               = '0;
      gest             = bcgd_pkg::G_IDLE;
      pend_gest        = bcgd_pkg::G_IDLE;
      pend_valid       = 1'b0;
      acc_level        = 1'b0;
      bounce_left      = 8'd0;
      stamp_ms         = 16'd0;
      toggles          = 3'b000;
      action_queue.delete();
      fails            = 0;
    end else begin
      // event transaction
      if (m_tvalid && m_tready) begin
        got.action          = bcgd_pkg::act_t'(m_tdata[3:0]);
        got.handler_given   = m_tdata[4];
        got.default_command = bcgd_pkg::def_cmd_t'(m_tdata[6:5]);
        got.toggle_value    = m_tdata[7];
        got.gesture_after   = bcgd_pkg::gesture_t'(m_tdata[11:8]);
        got.last            = m_tlast;
        if (action_queue.size() == 0) begin
          if (fails < 10)
            $display("%0t: event with none owed: tdata=%h tlast=%b", $time, m_tdata, m_tlast);
          fails++;
        end else begin
          want = action_queue.pop_front();
          if (got !== want) begin
            if (fails < 10)
              $display({"%0t: event mismatch: want act=%0d hnd=%0b def=%0d tog=%0b ",
                        "gest=%0d last=%0b, got act=%0d hnd=%0b def=%0d tog=%0b ",
                        "gest=%0d last=%0b"}, $time,
                       want.action, want.handler_given, want.default_command,
                       want.toggle_value, want.gesture_after, want.last,
                       got.action, got.handler_given, got.default_command,
                       got.toggle_value, got.gesture_after, got.last);
            fails++;
          end
        end
      end

      // register write
      if (cfg_we) begin
        case (cfg_index)
          bcgd_pkg::CFG_ACTIVE_HIGH:     active_high      = cfg_data[0];
          bcgd_pkg::CFG_LONG_PRESS:      long_press_ms    = cfg_data;
          bcgd_pkg::CFG_REPEAT_DELAY:    repeat_delay_ms  = cfg_data;
          bcgd_pkg::CFG_REPEAT_PERIOD:   repeat_period_ms = cfg_data;
          bcgd_pkg::CFG_IDLE_TIMEOUT:    idle_timeout_ms  = cfg_data;
          bcgd_pkg::CFG_DEBOUNCE:        debounce_polls   = cfg_data[7:0];
          bcgd_pkg::CFG_HANDLER_PRESENT: hp = cfg_data[bcgd_pkg::HP_WIDTH-1:0];
          default: ;
        endcase
      end

      // poll transaction
      if (s_tvalid && s_tready) decode_poll(s_tdata[0], s_tdata[16:1], s_tuser[0]);
    end
    queued = action_queue.size();
  end

endmodule

// ----- tb/sv/tb_button_click_gesture_decoder.sv -----
// ----------------------------------------------------------------------------
// tb_button_click_gesture_decoder
// Drives polls of a simulated push button through the gesture decoder:
// directed runs over long press, repeats, multi-clicks, interrupt deferral,
// default commands, widest debounce and extreme settings, then random click
// sequences under changing settings, with random poll gaps and event-side stalls.
// ----------------------------------------------------------------------------
module tb_button_click_gesture_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int          RANDOM_POLLS = 100;
  localparam int          SETTLE_CYCLES = 8;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           cfg_we = 1'b0;
  logic [2:0]     cfg_index = bcgd_pkg::CFG_ACTIVE_HIGH;
  logic [15:0]    cfg_data = 16'd0;
  logic           s_tvalid = 1'b0;
  logic           s_tready;
  logic [23:0]    s_tdata = 24'd0;   // [0] level, [16:1] now_ms, [23:17] zero
  logic [0:0]     s_tuser = 1'b0;    // [0] mode
  logic           m_tvalid;
  logic           m_tready = 1'b0;
  logic [15:0]    m_tdata;           // [3:0] action, [4] handler_given,
                                     // [6:5] default_command, [7] toggle_value,
                                     // [11:8] gesture_after, [15:12] zero
  logic           m_tlast;

  int             fails;
  int             queued;
  int unsigned    cycles = 0;
  int             polls = 0;
  int             intr_left = 0;
  bit             calm = 1'b0;
  logic [15:0]    clock_ms = 16'd0;
  bcgd_pkg::cfg_t settings;

  button_click_gesture_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  bcgd_action_checker actions (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .fails     (fails),
    .queued    (queued)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[button_click_gesture_decoder] ERROR");
      $finish;
    end
  end

  // idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // event side back-pressure
  initial begin : sink_pacing
    int run, n;
    @(posedge clk);
    forever begin
      m_tready <= 1'b1;
      run = calm ? 1 : $urandom_range(1, 12);
      repeat (run) @(posedge clk);
      n = pick_gap();
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  // interrupt polls come in short bursts
  function automatic logic next_mode();
    if (intr_left > 0) begin
      intr_left--;
      return 1'b1;
    end
    if ($urandom_range(0, 9) == 0) begin
      intr_left = $urandom_range(0, 3);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void advance_clock(int tick);
    if ($urandom_range(0, 99) == 0) clock_ms = 16'($urandom);
    else clock_ms = clock_ms + 16'($urandom_range(0, tick));
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic apply_settings();
    write_reg(bcgd_pkg::CFG_ACTIVE_HIGH, {15'd0, settings.active_high});
    write_reg(bcgd_pkg::CFG_LONG_PRESS, settings.long_press_ms);
    write_reg(bcgd_pkg::CFG_REPEAT_DELAY, settings.repeat_delay_ms);
    write_reg(bcgd_pkg::CFG_REPEAT_PERIOD, settings.repeat_period_ms);
    write_reg(bcgd_pkg::CFG_IDLE_TIMEOUT, settings.idle_timeout_ms);
    write_reg(bcgd_pkg::CFG_DEBOUNCE, {8'd0, settings.debounce_polls});
    write_reg(bcgd_pkg::CFG_HANDLER_PRESENT, {2'd0, settings.handler_present});
    cfg_we <= 1'b0;
  endtask

  // one poll transaction
  task automatic send_poll(logic lvl, logic [15:0] now, logic intr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, now, lvl};
    s_tuser  <= intr;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    polls++;
  endtask

  // wait until every owed event is out, then let the block settle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (queued != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // hold the contact at one level for a number of polls, maybe with glitches
  task automatic hold_level(logic lvl, int count, int tick, bit noisy);
    logic v;
    repeat (count) begin
      advance_clock(tick);
      v = (noisy && $urandom_range(0, 19) == 0) ? ~lvl : lvl;
      send_poll(v, clock_ms, next_mode());
    end
  endtask

  // one to three clicks, each short or held into long press and repeats
  task automatic play_clicks(int tick);
    int   presses, hold, rest;
    logic on;
    presses = $urandom_range(1, 3);
    on      = settings.active_high;
    for (int k = 0; k < presses; k++) begin
      hold = settings.debounce_polls + 1 +
             (($urandom_range(0, 2) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 4));
      hold_level(on, hold, tick, 1'b1);
      rest = settings.debounce_polls + 1 +
             ((k == presses - 1 || $urandom_range(0, 4) == 0) ?
              $urandom_range(5, 25) : $urandom_range(0, 3));
      hold_level(~on, rest, tick, 1'b1);
    end
  endtask

  // contact chatter with random modes
  task automatic chatter(int tick);
    repeat ($urandom_range(5, 20)) begin
      advance_clock(tick);
      send_poll(1'($urandom_range(0, 1)), clock_ms, 1'($urandom_range(0, 1)));
    end
  endtask

  function automatic logic [15:0] roll_ms();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(5, 300));
  endfunction

  function automatic void roll_settings();
    settings.active_high      = 1'($urandom_range(0, 1));
    settings.long_press_ms    = roll_ms();
    settings.repeat_delay_ms  = roll_ms();
    settings.repeat_period_ms = roll_ms();
    settings.idle_timeout_ms  = roll_ms();
    settings.debounce_polls   = ($urandom_range(0, 9) == 0) ? 8'd8 : 8'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0:       settings.handler_present = 14'h0000;
      1:       settings.handler_present = 14'h3FFF;
      2:       settings.handler_present = 14'h2000;
      3:       settings.handler_present = 14'h1FFF;
      default: settings.handler_present = 14'($urandom);
    endcase
  endfunction

  // stimulus
  initial begin : stimulus
    int goal, tick, plays;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: all handlers, no debounce, short timers
    settings = '{1'b1, 16'd30, 16'd0, 16'd20, 16'd40, 8'd0, 14'h3FFF};
    apply_settings();
    send_poll(1'b0, 16'h0000, 1'b0);
    send_poll(1'b1, 16'hFFFF, 1'b1);   // press deferred by interrupt poll
    send_poll(1'b0, 16'hFFFF, 1'b1);   // release while deferral waits
    send_poll(1'b1, 16'hFFFF, 1'b1);   // press refused while deferral waits
    send_poll(1'b1, 16'h0003, 1'b0);   // deferred press flushed across the wrap
    send_poll(1'b1, 16'd40, 1'b0);     // long press
    send_poll(1'b1, 16'd41, 1'b0);     // first repeat, zero delay
    send_poll(1'b1, 16'd70, 1'b0);     // periodic repeat
    send_poll(1'b0, 16'd71, 1'b1);     // release deferred
    send_poll(1'b0, 16'd80, 1'b0);
    send_poll(1'b1, 16'd85, 1'b0);     // second press
    send_poll(1'b0, 16'd86, 1'b0);
    send_poll(1'b1, 16'd87, 1'b0);     // third press
    send_poll(1'b1, 16'd200, 1'b0);    // triple long press
    send_poll(1'b1, 16'd200, 1'b0);
    send_poll(1'b0, 16'd201, 1'b0);
    send_poll(1'b1, 16'd300, 1'b0);    // single click
    send_poll(1'b0, 16'd305, 1'b0);
    send_poll(1'b0, 16'd400, 1'b0);    // idle timeout ends the click

    // directed: default target only, so press and release fall back to commands
    drain();
    settings.handler_present = 14'h2000;
    apply_settings();
    send_poll(1'b1, 16'd500, 1'b0);
    send_poll(1'b0, 16'd510, 1'b0);
    send_poll(1'b0, 16'd600, 1'b0);

    // widest debounce: press confirmed at once, release after a full count
    drain();
    settings = '{1'b0, 16'd100, 16'd50, 16'd30, 16'd100, 8'd255, 14'h3FFF};
    apply_settings();
    hold_level(1'b0, 8, 2, 1'b0);
    hold_level(1'b1, 260, 2, 1'b0);

    // timers at their maximum
    drain();
    settings = '{1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd1, 14'h3FFF};
    apply_settings();
    clock_ms = 16'hFF00;
    repeat (3) play_clicks(30);

    // everything at its minimum
    drain();
    settings = '{1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 14'h0000};
    apply_settings();
    repeat (2) play_clicks(10);

    // random phases of click sequences and chatter
    goal = polls + RANDOM_POLLS;
    while (polls < goal) begin
      drain();
      calm = ($urandom_range(0, 3) == 0);
      roll_settings();
      apply_settings();
      tick  = $urandom_range(1, 40);
      plays = $urandom_range(1, 3);
      for (int k = 0; k < plays && polls < goal; k++) begin
        if ($urandom_range(0, 7) == 0) chatter(tick);
        else play_clicks(tick);
      end
    end

    // wrap up
    calm = 1'b0;
    drain();
    if (fails == 0 && queued == 0) begin
      $display("[button_click_gesture_decoder] OK");
    end else begin
      $display("[button_click_gesture_decoder] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/bcgd_pkg.sv
sv/bcgd_step.sv
sv/button_click_gesture_decoder.sv
tb/sv/bcgd_action_checker.sv
tb/sv/tb_button_click_gesture_decoder.sv
